// ===== rtl/subset_sum_range_search_unit_macros.svh =====
// Assertion macros shared by the checker.
`ifndef SUBSET_SUM_RANGE_SEARCH_UNIT_MACROS_SVH
`define SUBSET_SUM_RANGE_SEARCH_UNIT_MACROS_SVH

// Checked only outside reset.
`define SSRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SSRS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ssrs_pkg.sv =====
package ssrs_pkg;

  localparam int LIMIT_BITS = 36;
  localparam int IN_WEIGHT_BITS = 32;
  localparam int OUT_INDEX_BITS = 4;

  typedef struct packed {
    logic [IN_WEIGHT_BITS-1:0] weight;
    logic [LIMIT_BITS-1:0]     lower_part_limit;
    logic [LIMIT_BITS-1:0]     upper_part_limit;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic                      found;
    logic [OUT_INDEX_BITS-1:0] original_index;
    logic                      selected;
    logic                      overflow;
    logic                      end_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_NODE,
    B_BACK,
    B_EMIT,
    B_FAIL
  } back_state_t;

endpackage

// ===== rtl/subset_sum_range_search_unit.sv =====
// Subset-sum range search unit.
// Input channel (item_valid / item_stall / item): one weight per transfer,
// one per cycle. The transfer with item.last set closes the problem and
// carries both part limits. Up to MAX_ITEMS weights are kept, insertion
// sorted (descending, stable) as they arrive; extra weights set overflow.
// A closed problem goes into a two-entry job queue; the loader then takes
// the next problem at once and stalls only while that queue is full.
// The search engine walks the select-first depth-first tree one node or
// one backtrack level per cycle. Results then leave one per cycle while
// result_stall is low: N results on success, a single failure result
// otherwise, end_of_run on the last.
// result_stall holds the output register; the engine waits on it.
// Reset (rst, synchronous) empties the queue, drops any partial problem
// and clears result_valid.
module subset_sum_range_search_unit #(
  parameter int MAX_ITEMS = 16,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  ssrs_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output ssrs_pkg::out_item_t result
);
  import ssrs_pkg::*;

  localparam int WB = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
  localparam int IB = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CB = $clog2(MAX_ITEMS + 1);
  localparam int TB = WB + CB;
  localparam int SW = ((TB > 36) ? TB : 36) + 2;
  localparam int JW = 1 + CB + TB + 2 * SW + MAX_ITEMS * (WB + IB);

  logic          push, full, pop, not_empty;
  logic [JW-1:0] push_data, pop_data;

  ssrs_front #(.MAX_ITEMS(MAX_ITEMS), .WEIGHT_BITS(WEIGHT_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .job_valid  (push),
    .job        (push_data),
    .job_full   (full)
  );

  ssrs_fifo #(.WIDTH(JW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  ssrs_back #(.MAX_ITEMS(MAX_ITEMS), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_ready    (not_empty),
    .job          (pop_data),
    .job_pop      (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== rtl/ssrs_fifo.sv =====
module ssrs_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [1:0][WIDTH-1:0] mem;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/ssrs_front.sv =====
module ssrs_front #(
  parameter int MAX_ITEMS = 16,
  parameter int WEIGHT_BITS = 32,
  localparam int WB = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32,
  localparam int IB = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
  localparam int CB = $clog2(MAX_ITEMS + 1),
  localparam int TB = WB + CB,
  localparam int SW = ((TB > 36) ? TB : 36) + 2,
  localparam int JW = 1 + CB + TB + 2 * SW + MAX_ITEMS * (WB + IB)
) (
  input  logic              clk,
  input  logic              rst,
  input  ssrs_pkg::in_item_t item,
  input  logic              item_valid,
  output logic              item_stall,
  output logic              job_valid,
  output logic [JW-1:0]     job,
  input  logic              job_full
);
  import ssrs_pkg::*;

  logic [MAX_ITEMS-1:0][WB-1:0] wv, wv_next;
  logic [MAX_ITEMS-1:0][IB-1:0] iv, iv_next;
  logic [CB-1:0] count, count_next;
  logic [TB-1:0] total, total_next;
  logic          ovf, ovf_next;
  logic [MAX_ITEMS-1:0] ge;
  logic          accept;
  logic [WB-1:0] w_in;
  logic [SW-1:0] goal_min, goal_max;

  assign item_stall = job_full;
  assign accept     = item_valid && !item_stall;
  assign w_in       = item.weight[WB-1:0];

  // stored entries stay sorted, so ge is a prefix
  always_comb begin
    for (int j = 0; j < MAX_ITEMS; j++) begin
      ge[j] = (CB'(j) < count) && (wv[j] >= w_in);
    end
  end

  always_comb begin
    wv_next    = wv;
    iv_next    = iv;
    count_next = count;
    total_next = total;
    ovf_next   = ovf;
    if (accept) begin
      if (count < CB'(MAX_ITEMS)) begin
        if (!ge[0]) begin
          wv_next[0] = w_in;
          iv_next[0] = count[IB-1:0];
        end
        for (int j = 1; j < MAX_ITEMS; j++) begin
          if (!ge[j]) begin
            if (ge[j-1]) begin
              wv_next[j] = w_in;
              iv_next[j] = count[IB-1:0];
            end else begin
              wv_next[j] = wv[j-1];
              iv_next[j] = iv[j-1];
            end
          end
        end
        count_next = count + 1'b1;
        total_next = total + TB'(w_in);
      end else begin
        ovf_next = 1'b1;
      end
    end
  end

  assign goal_min = SW'(total_next) - SW'(item.upper_part_limit);
  assign goal_max = SW'(item.lower_part_limit);
  assign job_valid = accept && item.last;
  assign job = {ovf_next, count_next, total_next, goal_min, goal_max, wv_next, iv_next};

  always_ff @(posedge clk) begin
    wv <= wv_next;
    iv <= iv_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
      ovf   <= 1'b0;
    end else if (job_valid) begin
      count <= '0;
      total <= '0;
      ovf   <= 1'b0;
    end else begin
      count <= count_next;
      total <= total_next;
      ovf   <= ovf_next;
    end
  end

endmodule

// ===== rtl/ssrs_back.sv =====
module ssrs_back #(
  parameter int MAX_ITEMS = 16,
  parameter int WEIGHT_BITS = 32,
  localparam int WB = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32,
  localparam int IB = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
  localparam int CB = $clog2(MAX_ITEMS + 1),
  localparam int TB = WB + CB,
  localparam int SW = ((TB > 36) ? TB : 36) + 2,
  localparam int JW = 1 + CB + TB + 2 * SW + MAX_ITEMS * (WB + IB)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_ready,
  input  logic [JW-1:0]      job,
  output logic               job_pop,
  output logic               result_valid,
  input  logic               result_stall,
  output ssrs_pkg::out_item_t result
);
  import ssrs_pkg::*;

  back_state_t state, state_next;

  logic                         j_ovf;
  logic [CB-1:0]                j_count;
  logic [TB-1:0]                j_total;
  logic signed [SW-1:0]         j_gmin, j_gmax;
  logic [MAX_ITEMS-1:0][WB-1:0] j_wv;
  logic [MAX_ITEMS-1:0][IB-1:0] j_iv;

  logic                         ovf;
  logic [CB-1:0]                count;
  logic signed [SW-1:0]         total, gmin, gmax;
  logic [MAX_ITEMS-1:0][WB-1:0] wv;
  logic [MAX_ITEMS-1:0][IB-1:0] iv;

  logic [CB-1:0]        pos, pos_next, pos_m1;
  logic [CB-1:0]        rank, rank_next;
  logic signed [SW-1:0] chosen, chosen_next, rejected, rejected_next;
  logic [MAX_ITEMS-1:0] choice, choice_next;
  logic                 out_free, load_out;
  out_item_t            out_d;
  logic [IB-1:0]        rd_ix;
  logic signed [SW-1:0] w;
  logic [IB+3:0]        idx_ext;

  assign {j_ovf, j_count, j_total, j_gmin, j_gmax, j_wv, j_iv} = job;

  assign out_free = !result_valid || !result_stall;
  assign pos_m1   = pos - 1'b1;
  assign rd_ix    = (state == B_BACK) ? pos_m1[IB-1:0] : pos[IB-1:0];
  assign w        = SW'(wv[rd_ix]);
  assign idx_ext  = {4'b0, iv[rank[IB-1:0]]};

  always_comb begin
    state_next    = state;
    pos_next      = pos;
    rank_next     = rank;
    chosen_next   = chosen;
    rejected_next = rejected;
    choice_next   = choice;
    job_pop       = 1'b0;
    load_out      = 1'b0;
    out_d         = '0;
    case (state)
      B_IDLE: begin
        if (job_ready) begin
          job_pop       = 1'b1;
          pos_next      = '0;
          chosen_next   = '0;
          rejected_next = '0;
          choice_next   = '0;
          state_next    = j_ovf ? B_FAIL : B_NODE;
        end
      end
      B_NODE: begin
        if (chosen >= gmin) begin
          rank_next  = '0;
          state_next = B_EMIT;
        end else if (pos >= count || gmin > total - rejected) begin
          state_next = (pos == '0) ? B_FAIL : B_BACK;
        end else if (chosen + w <= gmax) begin
          choice_next[rd_ix] = 1'b1;
          chosen_next        = chosen + w;
          pos_next           = pos + 1'b1;
        end else begin
          rejected_next = rejected + w;
          pos_next      = pos + 1'b1;
        end
      end
      B_BACK: begin
        // undo one level; a select branch turns into its reject branch
        if (choice[rd_ix]) begin
          choice_next[rd_ix] = 1'b0;
          chosen_next        = chosen - w;
          rejected_next      = rejected + w;
          state_next         = B_NODE;
        end else begin
          rejected_next = rejected - w;
          pos_next      = pos_m1;
          if (pos_m1 == '0) begin
            state_next = B_FAIL;
          end
        end
      end
      B_EMIT: begin
        if (out_free) begin
          load_out             = 1'b1;
          out_d.found          = 1'b1;
          out_d.original_index = idx_ext[3:0];
          out_d.selected       = choice[rank[IB-1:0]];
          out_d.end_of_run     = (rank == count - 1'b1);
          rank_next            = rank + 1'b1;
          if (out_d.end_of_run) begin
            state_next = B_IDLE;
          end
        end
      end
      B_FAIL: begin
        if (out_free) begin
          load_out         = 1'b1;
          out_d.overflow   = ovf;
          out_d.end_of_run = 1'b1;
          state_next       = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      choice       <= '0;
    end else begin
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      choice <= choice_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    rank     <= rank_next;
    chosen   <= chosen_next;
    rejected <= rejected_next;
    if (load_out) begin
      result <= out_d;
    end
    if (job_pop) begin
      ovf   <= j_ovf;
      count <= j_count;
      total <= SW'(j_total);
      gmin  <= j_gmin;
      gmax  <= j_gmax;
      wv    <= j_wv;
      iv    <= j_iv;
    end
  end

endmodule

// ===== rtl/ssrs_checker.sv =====
`include "subset_sum_range_search_unit_macros.svh"

module ssrs_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input ssrs_pkg::in_item_t  item,
  input logic                result_valid,
  input logic                result_stall,
  input ssrs_pkg::out_item_t result
);
  import ssrs_pkg::*;

  `SSRS_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !result_valid, "result valid after reset")

  `SSRS_ASSERT(a_out_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")

  `SSRS_ASSERT(a_fail_single, result_valid && !result.found |-> result.end_of_run && !result.selected && result.original_index == 4'd0, "failure result malformed")

  `SSRS_ASSERT(a_ovf_is_fail, result_valid && result.overflow |-> !result.found, "overflow result marked found")

endmodule

bind subset_sum_range_search_unit ssrs_checker u_ssrs_checker (.*);

// ===== tb/sv/subset_sum_range_search_unit_test.sv =====
`timescale 1ns / 1ps

module subset_sum_range_search_unit_test;
  import ssrs_pkg::*;

  localparam int MAX_ITEMS = 16;
  localparam int WATCHDOG_LIMIT = 2000000;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  in_item_t item;
  logic result_valid;
  logic result_stall;
  out_item_t result;

  subset_sum_range_search_unit u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predictor state for the problem being loaded
  logic [31:0] load_weights[MAX_ITEMS];
  logic [3:0] load_index[MAX_ITEMS];
  int load_count;
  logic [35:0] load_total;
  bit load_overflow;
  logic [31:0] sorted_weights[MAX_ITEMS];
  logic choice[MAX_ITEMS];
  longint goal_lo;
  longint goal_hi;

  out_item_t expected_results[$];
  int errors;
  int idle_cycles;
  bit sender_idle_on;
  bit receiver_idle_on;

  function automatic bit dfs(int pos, longint chosen, longint rejected);
    longint w;
    if (chosen >= goal_lo) return 1'b1;
    if (pos >= load_count) return 1'b0;
    if (goal_lo > longint'(load_total) - rejected) return 1'b0;
    w = longint'(sorted_weights[pos]);
    if (chosen + w <= goal_hi) begin
      choice[pos] = 1'b1;
      if (dfs(pos + 1, chosen + w, rejected)) return 1'b1;
      choice[pos] = 1'b0;
    end
    return dfs(pos + 1, chosen, rejected + w);
  endfunction

  task automatic predict_partition(input in_item_t it);
    out_item_t r;
    int j;
    logic [31:0] w;
    logic [3:0] ix;
    bit ok;
    if (load_count < MAX_ITEMS) begin
      load_weights[load_count] = it.weight;
      load_index[load_count] = 4'(load_count);
      load_total = load_total + 36'(it.weight);
      load_count++;
    end else begin
      load_overflow = 1'b1;
    end
    if (!it.last) return;
    r = '0;
    r.end_of_run = 1'b1;
    if (load_overflow) begin
      r.overflow = 1'b1;
      expected_results.push_back(r);
    end else begin
      for (int i = 0; i < load_count; i++) begin
        sorted_weights[i] = load_weights[i];
        choice[i] = 1'b0;
      end
      // stable insertion sort, descending
      for (int i = 1; i < load_count; i++) begin
        w = sorted_weights[i];
        ix = load_index[i];
        j = i;
        while (j > 0 && sorted_weights[j - 1] < w) begin
          sorted_weights[j] = sorted_weights[j - 1];
          load_index[j] = load_index[j - 1];
          j--;
        end
        sorted_weights[j] = w;
        load_index[j] = ix;
      end
      goal_lo = longint'(load_total) - longint'(it.upper_part_limit);
      goal_hi = longint'(it.lower_part_limit);
      ok = dfs(0, 0, 0);
      if (!ok) begin
        expected_results.push_back(r);
      end else begin
        for (int i = 0; i < load_count; i++) begin
          r.found = 1'b1;
          r.original_index = load_index[i];
          r.selected = choice[i];
          r.overflow = 1'b0;
          r.end_of_run = (i == load_count - 1);
          expected_results.push_back(r);
        end
      end
    end
    load_count = 0;
    load_total = '0;
    load_overflow = 1'b0;
  endtask

  // valid stays high after the transfer; the next call or wait_drained moves it
  task automatic send_weight(input logic [31:0] w, input bit last_w,
                             input logic [35:0] lo, input logic [35:0] hi);
    int gap;
    in_item_t it;
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    it.weight = w;
    it.last = last_w;
    it.lower_part_limit = last_w ? lo : 36'($urandom());
    it.upper_part_limit = last_w ? hi : 36'($urandom());
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_partition(it);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_weight(int mode);
    case (mode)
      0: return $urandom_range(0, 15);
      1: return $urandom_range(0, 1000);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  // one problem with n weights; limits near half the total, random, or the total
  task automatic send_problem(input int n, input int mode, input int limit_mode);
    logic [31:0] ws[$];
    logic [35:0] total;
    logic [35:0] lo;
    logic [35:0] hi;
    total = '0;
    for (int i = 0; i < n; i++) begin
      ws.push_back(rand_weight(mode));
      total = total + 36'(ws[i]);
    end
    case (limit_mode)
      0: begin
        lo = total / 2 + $urandom_range(0, 3);
        hi = total - total / 2 + $urandom_range(0, 3);
      end
      1: begin
        lo = total / 2;
        hi = total - lo - $urandom_range(0, 2);
      end
      2: begin
        lo = 36'($urandom()) ^ (36'($urandom_range(0, 15)) << 32);
        hi = 36'($urandom()) ^ (36'($urandom_range(0, 15)) << 32);
      end
      default: begin
        lo = total;
        hi = total;
      end
    endcase
    for (int i = 0; i < n; i++)
      send_weight(ws[i], i == n - 1, lo, hi);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_extremes();
    send_weight(32'd0, 1'b1, 36'd0, 36'd0);
    send_weight(32'hFFFF_FFFF, 1'b0, 36'd0, 36'd0);
    send_weight(32'hFFFF_FFFF, 1'b1, 36'hF_FFFF_FFFF, 36'hF_FFFF_FFFF);
    send_weight(32'hFFFF_FFFF, 1'b0, 36'd0, 36'd0);
    send_weight(32'h1, 1'b1, 36'd0, 36'd0);
    // equal weights keep load order
    for (int i = 0; i < 4; i++)
      send_weight(32'd7, i == 3, 36'd14, 36'd14);
    // infeasible: needs 5..3
    send_weight(32'd4, 1'b0, 36'd0, 36'd0);
    send_weight(32'd4, 1'b1, 36'd3, 36'd3);
    // minimum at or below zero
    send_weight(32'd9, 1'b0, 36'd0, 36'd0);
    send_weight(32'd3, 1'b1, 36'd0, 36'd100);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < MAX_ITEMS + 2; i++)
      send_weight($urandom_range(0, 50), i == MAX_ITEMS + 1, 36'd100, 36'd100);
    wait_drained();
  endtask

  task automatic test_full_size();
    send_problem(MAX_ITEMS, 1, 0);
    send_problem(MAX_ITEMS, 3, 1);
  endtask

  task automatic test_random(input int count);
    int n;
    while (count > 0) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 7);
      send_problem(n, $urandom_range(0, 3), $urandom_range(0, 3));
      count -= n;
    end
  endtask

  always @(negedge clk) begin
    if (rst || !receiver_idle_on) begin
      result_stall <= 1'b0;
    end else if (idle_cycles > 0) begin
      idle_cycles <= idle_cycles - 1;
      result_stall <= (idle_cycles > 1);
    end else if ($urandom_range(0, 5) == 0) begin
      idle_cycles <= $urandom_range(1, 19);
      result_stall <= 1'b1;
    end
  end

  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result);
          errors++;
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          if (e.found !== result.found || e.original_index !== result.original_index ||
              e.selected !== result.selected || e.overflow !== result.overflow ||
              e.end_of_run !== result.end_of_run) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, result);
            errors++;
          end
        end
      end
      if ((result_valid && !result_stall) || (item_valid && !item_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    errors = 0;
    idle_cycles = 0;
    quiet_cycles = 0;
    load_count = 0;
    load_total = '0;
    load_overflow = 1'b0;
    sender_idle_on = 1'b1;
    receiver_idle_on = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_overflow();
    test_full_size();
    test_random(200);
    wait_drained();
    test_random(60);
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    test_random(60);
    wait_drained();
    repeat (50) @(negedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
